// ----- rtl/imm_pkg.sv -----
// Shared types and constants for the integer matrix multiply block.
// Payload structs, the pipeline tag, the sequencer states and width helpers.
// No dependencies.
package imm_pkg;

    localparam int ELEM_BITS   = 16;
    localparam int PROD_W      = 2 * ELEM_BITS;
    localparam int C_W         = 35;
    localparam int RC_W        = 3;
    localparam int DIM_W       = 4;
    localparam int DIM_RESET   = 8;
    localparam int MAX_DIM_DEF = 8;

    // Address width of a store holding max_dim * max_dim entries
    function automatic int addr_w(input int max_dim);
        int depth;
        depth = max_dim * max_dim;
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // Width of a row, column or inner-product index
    function automatic int idx_w(input int max_dim);
        return (max_dim > 1) ? $clog2(max_dim) : 1;
    endfunction

    typedef struct packed {
        logic signed [ELEM_BITS-1:0] a_elem;
        logic signed [ELEM_BITS-1:0] b_elem;
    } imm_in_t;

    typedef struct packed {
        logic signed [C_W-1:0] c_value;
        logic [RC_W-1:0]       row;
        logic [RC_W-1:0]       col;
        logic                  last;
    } imm_out_t;

    // Travels alongside each multiply-accumulate step
    typedef struct packed {
        logic            first;
        logic            lastk;
        logic            last;
        logic [RC_W-1:0] row;
        logic [RC_W-1:0] col;
    } imm_tag_t;

    typedef enum logic {
        ST_LOAD,
        ST_CALC
    } imm_state_t;

endpackage

// ----- rtl/imm_store.sv -----
// Element stores for matrices A and B: one write port, one read port each.
// Read data is registered. Depends on imm_pkg.
module imm_store #(
    parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [imm_pkg::addr_w(MAX_DIM)-1:0]        waddr,
    input  imm_pkg::imm_in_t                           wdata,
    input  logic                                       re,
    input  logic [imm_pkg::addr_w(MAX_DIM)-1:0]        a_raddr,
    input  logic [imm_pkg::addr_w(MAX_DIM)-1:0]        b_raddr,
    output logic signed [imm_pkg::ELEM_BITS-1:0]       a_rdata,
    output logic signed [imm_pkg::ELEM_BITS-1:0]       b_rdata
);
    import imm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;

    logic [ELEM_BITS-1:0] a_mem [DEPTH];
    logic [ELEM_BITS-1:0] b_mem [DEPTH];

    // Write one loaded pair
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            a_mem[waddr] <= wdata.a_elem;
            b_mem[waddr] <= wdata.b_elem;
        end
    end

    // Read operands; hold while the pipeline is stalled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            a_rdata <= a_mem[a_raddr];
            b_rdata <= b_mem[b_raddr];
        end
    end

endmodule

// ----- rtl/imm_mac.sv -----
// Multiply-accumulate pipeline and result register for the matrix multiply.
// Takes registered store data plus a step tag; depends on imm_pkg.
module imm_mac (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 issue,
    input  imm_pkg::imm_tag_t                    issue_tag,
    input  logic signed [imm_pkg::ELEM_BITS-1:0] a_rdata,
    input  logic signed [imm_pkg::ELEM_BITS-1:0] b_rdata,
    output logic                                 stall,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output imm_pkg::imm_out_t                    res
);
    import imm_pkg::*;

    logic                     v1_reg;
    logic                     v2_reg;
    imm_tag_t                 tag1_reg;
    imm_tag_t                 tag2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [C_W-1:0]    acc_reg;
    logic signed [C_W-1:0]    acc_sum;
    logic                     res_valid_reg;
    imm_out_t                 res_reg;

    // Freeze everything when a finished element cannot be parked
    assign stall = v2_reg && tag2_reg.lastk && res_valid_reg && !res_ready;

    // Restart the sum on the first step of each element
    assign acc_sum = (tag2_reg.first ? '0 : acc_reg) + C_W'(prod_reg);

    // Advance stage valids and the result flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (!stall)
            begin
                v1_reg <= issue;
                v2_reg <= v1_reg;
            end
            // Post a finished element, else drop the flag once the item is taken
            if (v2_reg && tag2_reg.lastk && !stall)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Multiply, accumulate and capture finished elements
    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            tag1_reg <= issue_tag;
            tag2_reg <= tag1_reg;
            prod_reg <= a_rdata * b_rdata;
            if (v2_reg)
            begin
                acc_reg <= acc_sum;
            end
            if (v2_reg && tag2_reg.lastk)
            begin
                res_reg.c_value <= acc_sum;
                res_reg.row     <= tag2_reg.row;
                res_reg.col     <= tag2_reg.col;
                res_reg.last    <= tag2_reg.last;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_finish_posts: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && tag2_reg.lastk && !stall |=> res_valid_reg)
        else $error("finished element not posted to the result register");

    a_post_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(v2_reg && tag2_reg.lastk))
        else $error("result raised without a finishing step");

    a_stage_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(v1_reg) |-> $past(issue))
        else $error("pipeline stage filled without an issued step");

endmodule

// ----- rtl/integer_matrix_multiply.sv -----
// Top level of the signed integer matrix multiply, C = A x B.
// Holds the load/compute sequencer; uses imm_pkg, imm_store and imm_mac.
//
// Items carry one element of A and one of B at the same row-major position.
// After dim*dim items the block computes C with a single multiply-accumulate
// unit fed from two element stores, one step per cycle while the result side
// does not stall, and results come out row-major, with row, column and a last
// flag. While the product is computed no item is taken; loading of the next
// pair of matrices starts as soon as the last step has read the stores.
// The user must write matrix_dim only while idle; the block itself does not
// enforce this. 0 acts as 1 and values above MAX_DIM act as MAX_DIM.
// Stores are not cleared at reset.
module integer_matrix_multiply #(
    parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  imm_pkg::imm_in_t              item,
    output logic                          res_valid,
    input  logic                          res_ready,
    output imm_pkg::imm_out_t             res,
    input  logic                          dim_we,
    input  logic [imm_pkg::DIM_W-1:0]     dim_wdata
);
    import imm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = addr_w(MAX_DIM);
    localparam int IW    = idx_w(MAX_DIM);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int NN_W  = 2 * DIM_W;

    imm_state_t         state_reg, state_next;
    logic [DIM_W-1:0]   dim_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [IW-1:0]      r_reg, r_next;
    logic [IW-1:0]      c_reg, c_next;
    logic [IW-1:0]      k_reg, k_next;
    logic [AW-1:0]      row_base_reg, row_base_next;
    logic [AW-1:0]      a_addr_reg, a_addr_next;
    logic [AW-1:0]      b_addr_reg, b_addr_next;

    logic [DIM_W-1:0]   d_use;
    logic [DIM_W-1:0]   d_max;
    logic [AW-1:0]      d_aw;
    logic [NN_W-1:0]    n_elems;
    logic [CNT_W-1:0]   cnt_inc;
    logic               k_last, c_last, r_last;
    logic               issue;
    logic               stall;
    logic               load_we;
    imm_tag_t           issue_tag;
    logic signed [ELEM_BITS-1:0] a_rdata;
    logic signed [ELEM_BITS-1:0] b_rdata;

    // Clamp the dimension into the supported range
    assign d_max   = DIM_W'(MAX_DIM);
    assign d_use   = (dim_reg == '0) ? DIM_W'(1) : ((dim_reg > d_max) ? d_max : dim_reg);
    assign d_aw    = AW'(d_use);
    assign n_elems = NN_W'(d_use) * NN_W'(d_use);
    assign cnt_inc = cnt_reg + CNT_W'(1);

    assign k_last = (DIM_W'(k_reg) == d_use - DIM_W'(1));
    assign c_last = (DIM_W'(c_reg) == d_use - DIM_W'(1));
    assign r_last = (DIM_W'(r_reg) == d_use - DIM_W'(1));

    assign issue   = (state_reg == ST_CALC);
    assign load_we = item_valid && item_ready;

    // Tag each step with its place in the product
    always_comb
    begin
        issue_tag.first = (k_reg == '0);
        issue_tag.lastk = k_last;
        issue_tag.last  = k_last && c_last && r_last;
        issue_tag.row   = RC_W'(r_reg);
        issue_tag.col   = RC_W'(c_reg);
    end

    // Hold the dimension register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg <= DIM_W'(DIM_RESET);
        end
        else if (dim_we)
        begin
            dim_reg <= dim_wdata;
        end
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            cnt_reg      <= '0;
            r_reg        <= '0;
            c_reg        <= '0;
            k_reg        <= '0;
            row_base_reg <= '0;
            a_addr_reg   <= '0;
            b_addr_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            r_reg        <= r_next;
            c_reg        <= c_next;
            k_reg        <= k_next;
            row_base_reg <= row_base_next;
            a_addr_reg   <= a_addr_next;
            b_addr_reg   <= b_addr_next;
        end
    end

    // Load items, then walk rows, columns and the inner index
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        r_next        = r_reg;
        c_next        = c_reg;
        k_next        = k_reg;
        row_base_next = row_base_reg;
        a_addr_next   = a_addr_reg;
        b_addr_next   = b_addr_reg;
        item_ready    = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    if (NN_W'(cnt_inc) >= n_elems)
                    begin
                        cnt_next      = '0;
                        state_next    = ST_CALC;
                        r_next        = '0;
                        c_next        = '0;
                        k_next        = '0;
                        row_base_next = '0;
                        a_addr_next   = '0;
                        b_addr_next   = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_inc;
                    end
                end
            end
            ST_CALC:
            begin
                if (!stall)
                begin
                    if (!k_last)
                    begin
                        k_next      = k_reg + IW'(1);
                        a_addr_next = a_addr_reg + AW'(1);
                        b_addr_next = b_addr_reg + d_aw;
                    end
                    else
                    begin
                        k_next = '0;
                        if (!c_last)
                        begin
                            c_next      = c_reg + IW'(1);
                            a_addr_next = row_base_reg;
                            b_addr_next = AW'(c_reg) + AW'(1);
                        end
                        else
                        begin
                            c_next      = '0;
                            b_addr_next = '0;
                            if (!r_last)
                            begin
                                r_next        = r_reg + IW'(1);
                                row_base_next = row_base_reg + d_aw;
                                a_addr_next   = row_base_reg + d_aw;
                            end
                            else
                            begin
                                r_next        = '0;
                                row_base_next = '0;
                                a_addr_next   = '0;
                                state_next    = ST_LOAD;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    imm_store #(
        .MAX_DIM (MAX_DIM)
    ) u_store (
        .clk     (clk),
        .we      (load_we),
        .waddr   (cnt_reg[AW-1:0]),
        .wdata   (item),
        .re      (issue && !stall),
        .a_raddr (a_addr_reg),
        .b_raddr (b_addr_reg),
        .a_rdata (a_rdata),
        .b_rdata (b_rdata)
    );

    imm_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .issue_tag (issue_tag),
        .a_rdata   (a_rdata),
        .b_rdata   (b_rdata),
        .stall     (stall),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < CNT_W'(DEPTH))
        else $error("load count beyond store depth");

    a_row_addr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CALC |-> a_addr_reg == row_base_reg + AW'(k_reg))
        else $error("A read address out of step with row and inner index");

    a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_CALC) |-> cnt_reg == '0)
        else $error("load count not cleared on entry to compute");

endmodule

// ----- test/imm_product_checker.sv -----
// Checker for the integer matrix multiply: watches the item, result and dimension ports,
// keeps its own copy of the element stores and predicts every product element.
// Depends on imm_pkg for the payload structs and the dimension constants.
module imm_product_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    input  logic                          item_ready,
    input  imm_pkg::imm_in_t              item,
    input  logic                          res_valid,
    input  logic                          res_ready,
    input  imm_pkg::imm_out_t             res,
    input  logic                          dim_we,
    input  logic [imm_pkg::DIM_W-1:0]     dim_wdata,
    output int                            fail_count,
    output int                            elems_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import imm_pkg::*;

    localparam int STORE_DEPTH = 64;

    logic [DIM_W-1:0]            dim_setting;
    logic signed [ELEM_BITS-1:0] a_mem [STORE_DEPTH];
    logic signed [ELEM_BITS-1:0] b_mem [STORE_DEPTH];
    int                          pairs_loaded;
    imm_out_t                    product_due [$];

    imm_out_t                    want;
    int                          dim_used;
    longint                      dot;

    // Dimension in force: zero acts as one, anything above the maximum as the maximum
    function automatic int effective_dim(input logic [DIM_W-1:0] setting);
        if (setting == 0)
            return 1;
        if (setting > MAX_DIM_DEF)
            return MAX_DIM_DEF;
        return int'(setting);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_setting  = DIM_W'(DIM_RESET);
            pairs_loaded = 0;
            product_due.delete();
            fail_count   = 0;
            elems_due    = 0;
        end
        else
        begin
            // Compare each taken result element with the oldest prediction
            if (res_valid && res_ready)
            begin
                if (product_due.size() == 0)
                begin
                    $display({"%0t ns: unexpected result, expected none, ",
                              "got c=%0d row=%0d col=%0d last=%0b"},
                             $time, res.c_value, res.row, res.col, res.last);
                    fail_count++;
                end
                else
                begin
                    want = product_due.pop_front();
                    if (res.c_value !== want.c_value || res.row !== want.row ||
                        res.col !== want.col || res.last !== want.last)
                    begin
                        $display({"%0t ns: expected c=%0d row=%0d col=%0d last=%0b, ",
                                  "got c=%0d row=%0d col=%0d last=%0b"},
                                 $time, want.c_value, want.row, want.col, want.last,
                                 res.c_value, res.row, res.col, res.last);
                        fail_count++;
                    end
                end
            end

            // Store the pair; once the count reaches the matrix size, predict all of C
            if (item_valid && item_ready)
            begin
                dim_used = effective_dim(dim_setting);
                a_mem[pairs_loaded % STORE_DEPTH] = item.a_elem;
                b_mem[pairs_loaded % STORE_DEPTH] = item.b_elem;
                pairs_loaded = (pairs_loaded + 1) & 8'h7F;
                if (pairs_loaded >= dim_used * dim_used)
                begin
                    for (int r = 0; r < dim_used; r++)
                    begin
                        for (int c = 0; c < dim_used; c++)
                        begin
                            dot = 0;
                            for (int k = 0; k < dim_used; k++)
                                dot += longint'(a_mem[(r * dim_used + k) % STORE_DEPTH]) *
                                       longint'(b_mem[(k * dim_used + c) % STORE_DEPTH]);
                            want.c_value = dot[C_W-1:0];
                            want.row     = RC_W'(r);
                            want.col     = RC_W'(c);
                            want.last    = (r == dim_used - 1) && (c == dim_used - 1);
                            product_due.push_back(want);
                        end
                    end
                    pairs_loaded = 0;
                end
            end

            // Track the dimension register; a write applies from the next item on
            if (dim_we)
                dim_setting = dim_wdata;

            elems_due = product_due.size();
        end
    end

endmodule

// ----- test/tb_integer_matrix_multiply.sv -----
// Testbench top for the integer matrix multiply: clock, reset, stimulus and verdict.
// Depends on imm_pkg, the integer_matrix_multiply block and imm_product_checker.
module tb_integer_matrix_multiply;
    timeunit 1ns;
    timeprecision 1ps;

    import imm_pkg::*;

    // Cycles to let the block settle once nothing more is expected
    localparam int SETTLE = 16;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             item_valid = 1'b0;
    logic             item_ready;
    imm_in_t          item       = '0;
    logic             res_valid;
    logic             res_ready  = 1'b0;
    imm_out_t         res;
    logic             dim_we     = 1'b0;
    logic [DIM_W-1:0] dim_wdata  = '0;

    int               fail_count;
    int               elems_due;
    int               send_idle_pct = 0;
    int               stall_pct     = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    integer_matrix_multiply dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .dim_we     (dim_we),
        .dim_wdata  (dim_wdata)
    );

    imm_product_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .dim_we     (dim_we),
        .dim_wdata  (dim_wdata),
        .fail_count (fail_count),
        .elems_due  (elems_due)
    );

    // Stall the result side at random
    always @(negedge clk)
        res_ready <= ($urandom_range(99) >= stall_pct);

    // Offer one pair, idling first at random; valid stays high on return
    task automatic send_pair(input logic signed [ELEM_BITS-1:0] a,
                             input logic signed [ELEM_BITS-1:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid  <= 1'b1;
        item.a_elem <= a;
        item.b_elem <= b;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid and wait until every predicted element has been taken
    task automatic drain();
        item_valid <= 1'b0;
        while (elems_due != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_dim(input logic [DIM_W-1:0] value);
        drain();
        dim_we    <= 1'b1;
        dim_wdata <= value;
        @(negedge clk);
        dim_we    <= 1'b0;
    endtask

    // Full-range value, with the extremes and small values favoured
    function automatic logic signed [ELEM_BITS-1:0] pick_elem();
        case ($urandom_range(7))
            0:       return {1'b1, {(ELEM_BITS-1){1'b0}}};
            1:       return {1'b0, {(ELEM_BITS-1){1'b1}}};
            2:       return '1;
            3:       return '0;
            4:       return ELEM_BITS'($urandom_range(15));
            default: return ELEM_BITS'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [DIM_W-1:0]            dim_value;
        int                          mats;
        int                          side;
        logic signed [ELEM_BITS-1:0] most_neg;
        logic signed [ELEM_BITS-1:0] most_pos;

        most_neg = {1'b1, {(ELEM_BITS-1){1'b0}}};
        most_pos = {1'b0, {(ELEM_BITS-1){1'b1}}};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // One by one: extreme products
        set_dim(4'd1);
        send_pair(most_neg, most_neg);
        send_pair(most_pos, most_pos);
        send_pair(most_neg, most_pos);
        send_pair(most_pos, most_neg);
        send_pair(16'sd0, 16'sd0);
        send_pair(-16'sd1, -16'sd1);

        // Dimension zero behaves as one
        set_dim(4'd0);
        send_pair(16'sd1234, -16'sd5);

        // Small known product
        set_dim(4'd2);
        send_pair(16'sd1, 16'sd5);
        send_pair(16'sd2, 16'sd6);
        send_pair(16'sd3, 16'sd7);
        send_pair(16'sd4, 16'sd8);

        // Shrink the dimension part way through a load: count already past the size
        set_dim(4'd3);
        for (int i = 0; i < 5; i++)
            send_pair(ELEM_BITS'(i - 2), ELEM_BITS'(3 * i + 1));
        set_dim(4'd2);
        send_pair(-16'sd7, 16'sd9);

        // Grow the dimension part way through a load
        set_dim(4'd2);
        send_pair(16'sd11, -16'sd3);
        send_pair(-16'sd100, 16'sd250);
        set_dim(4'd3);
        for (int i = 0; i < 7; i++)
            send_pair(pick_elem(), pick_elem());

        // Random matrices under each idling pattern
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:       begin dim_value = 4'd3;  mats = 2; end
                1:       begin dim_value = 4'd2;  mats = 4; end
                2:       begin dim_value = 4'd8;  mats = 1; end
                3:       begin dim_value = 4'd15; mats = 1; end
                default: begin dim_value = 4'd1;  mats = 8; end
            endcase
            set_dim(dim_value);
            side = (dim_value > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(dim_value);
            for (int m = 0; m < mats; m++)
            begin
                case ((ph == 4) ? m % 4 : ph % 4)
                    0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                    1:       begin send_idle_pct = 70; stall_pct = 0;  end
                    2:       begin send_idle_pct = 0;  stall_pct = 70; end
                    default: begin send_idle_pct = 10; stall_pct = 10; end
                endcase
                for (int i = 0; i < side * side; i++)
                begin
                    // The full-size matrix of most negative values gives the largest sums
                    if (ph == 2)
                        send_pair(most_neg, most_neg);
                    else
                        send_pair(pick_elem(), pick_elem());
                end
            end
        end

        drain();
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Timeout guard
    initial
    begin
        #1_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- integer_matrix_multiply.f -----
rtl/imm_pkg.sv
rtl/imm_store.sv
rtl/imm_mac.sv
rtl/integer_matrix_multiply.sv
test/imm_product_checker.sv
test/tb_integer_matrix_multiply.sv
